// ===== rtl/bpc_pkg.sv =====
// Shared types and codes for the button press classifier.
// Holds phase, kind, status and register index codes, the config struct and the result struct.
// No dependencies.
package bpc_pkg;

	localparam int TimeW = 32;
	localparam int RegW = 16;
	localparam int IdxW = 3;

	localparam logic [2:0] PH_IDLE      = 3'd0;
	localparam logic [2:0] PH_DEBOUNCE  = 3'd1;
	localparam logic [2:0] PH_DETERMINE = 3'd2;
	localparam logic [2:0] PH_SHORT     = 3'd3;
	localparam logic [2:0] PH_DOUBLE    = 3'd4;
	localparam logic [2:0] PH_LONG      = 3'd5;
	localparam logic [2:0] PH_END       = 3'd6;

	localparam logic [1:0] KIND_NONE   = 2'd0;
	localparam logic [1:0] KIND_SHORT  = 2'd1;
	localparam logic [1:0] KIND_DOUBLE = 2'd2;
	localparam logic [1:0] KIND_LONG   = 2'd3;

	localparam logic [2:0] ST_REFRESH = 3'd0;
	localparam logic [2:0] ST_IDLE    = 3'd1;
	localparam logic [2:0] ST_BOUNCE  = 3'd2;
	localparam logic [2:0] ST_BUSY    = 3'd3;
	localparam logic [2:0] ST_DONE    = 3'd4;

	localparam logic [IdxW-1:0] REG_USE_DOUBLE   = 3'd0;
	localparam logic [IdxW-1:0] REG_SINGLE_LONG  = 3'd1;
	localparam logic [IdxW-1:0] REG_ACTIVE_HIGH  = 3'd2;
	localparam logic [IdxW-1:0] REG_HOLD_STATE   = 3'd3;
	localparam logic [IdxW-1:0] REG_REFRESH_GAP  = 3'd4;
	localparam logic [IdxW-1:0] REG_LONG_PRESS   = 3'd5;
	localparam logic [IdxW-1:0] REG_DOUBLE_GAP   = 3'd6;
	localparam logic [IdxW-1:0] REG_DEBOUNCE     = 3'd7;

	typedef struct packed {
		logic            use_double_press;
		logic            single_long_event;
		logic            active_high;
		logic [RegW-1:0] hold_state_ms;
		logic [RegW-1:0] refresh_gap_ms;
		logic [RegW-1:0] long_press_ms;
		logic [RegW-1:0] double_gap_ms;
		logic [RegW-1:0] debounce_ms;
	} cfg_t;

	typedef struct packed {
		logic [2:0] status;
		logic [1:0] press_kind;
		logic [1:0] event_fired;
	} result_t;

endpackage

// ===== rtl/button_press_classifier.sv =====
// Button press classifier: turns timestamped pin polls into press gestures.
// Top level; instantiates bpc_cfg and bpc_core and uses bpc_pkg.
//
// Each input beat is one poll: raw_level and its millisecond timestamp now_ms.
// Each poll gives exactly one output beat with status, press_kind and
// event_fired. A beat moves when valid is high and stall is low.
// A poll lands in an input register, is classified against the gesture state
// and lands in the output register. One poll is taken per cycle while in_stall
// is low. When the receiver stalls, the output beat holds; the input register
// still accepts one more poll, then in_stall rises until the output beat leaves.
// Configuration registers are written through wr_en, wr_index and wr_data while
// no poll is in flight; the user must keep to this, the block does not enforce
// it. Reset clears the gesture state and loads the register defaults; no output
// beat is pending after reset.
module button_press_classifier import bpc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [IdxW-1:0]  wr_index,
	input  logic [RegW-1:0]  wr_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             raw_level,
	input  logic [TimeW-1:0] now_ms,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [2:0]       status,
	output logic [1:0]       press_kind,
	output logic [1:0]       event_fired
);

	cfg_t             cfg;
	result_t          res;
	logic             valid_s1;
	logic             level_s1;
	logic [TimeW-1:0] now_s1;
	logic             valid_s2;
	result_t          res_s2;
	logic             advance;

	bpc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	assign advance = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			level_s1 <= raw_level;
			now_s1 <= now_ms;
		end
	end

	bpc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.step      (advance),
		.raw_level (level_s1),
		.now_ms    (now_s1),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || !out_stall) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid = valid_s2;
	assign status = res_s2.status;
	assign press_kind = res_s2.press_kind;
	assign event_fired = res_s2.event_fired;

	a_event_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.event_fired != KIND_NONE) |-> res_s2.press_kind == res_s2.event_fired)
		else $error("event raised without matching held kind");

	a_refresh_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (res_s2.status == ST_REFRESH || res_s2.status == ST_DONE))
		|-> res_s2.event_fired == KIND_NONE)
		else $error("event raised on a refresh or completion poll");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled without a blocked output");

	a_advance_moves: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("classified poll did not reach the output register");

endmodule

// ===== rtl/bpc_cfg.sv =====
// Configuration register file of the button press classifier.
// Depends on bpc_pkg for the register indexes and the config struct.
module bpc_cfg import bpc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [IdxW-1:0]     wr_index,
	input  logic [RegW-1:0]     wr_data,
	output cfg_t                cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.use_double_press  <= 1'b0;
			cfg_q.single_long_event <= 1'b0;
			cfg_q.active_high       <= 1'b1;
			cfg_q.hold_state_ms     <= 16'd1000;
			cfg_q.refresh_gap_ms    <= 16'd10;
			cfg_q.long_press_ms     <= 16'd1000;
			cfg_q.double_gap_ms     <= 16'd300;
			cfg_q.debounce_ms       <= 16'd20;
		end else if (wr_en) begin
			case (wr_index)
				REG_USE_DOUBLE:  cfg_q.use_double_press  <= wr_data[0];
				REG_SINGLE_LONG: cfg_q.single_long_event <= wr_data[0];
				REG_ACTIVE_HIGH: cfg_q.active_high       <= wr_data[0];
				REG_HOLD_STATE:  cfg_q.hold_state_ms     <= wr_data;
				REG_REFRESH_GAP: cfg_q.refresh_gap_ms    <= wr_data;
				REG_LONG_PRESS:  cfg_q.long_press_ms     <= wr_data;
				REG_DOUBLE_GAP:  cfg_q.double_gap_ms     <= wr_data;
				REG_DEBOUNCE:    cfg_q.debounce_ms       <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/bpc_core.sv =====
// Gesture state machine of the button press classifier: one poll per step.
// Computes the result of a poll and updates the gesture state when step is high.
// Depends on bpc_pkg.
module bpc_core import bpc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             step,
	input  logic             raw_level,
	input  logic [TimeW-1:0] now_ms,
	output result_t          res
);

	logic [2:0]       phase_q, phase_d;
	logic [TimeW-1:0] press_start_q, press_start_d;
	logic [TimeW-1:0] done_time_q, done_time_d;
	logic             hold_pending_q, hold_pending_d;
	logic [1:0]       kind_q, kind_d;

	logic             pressed;
	logic [TimeW-1:0] since_done;
	logic [TimeW-1:0] since_press;
	logic [RegW+1:0]  double_min;

	assign pressed = (raw_level == cfg.active_high);
	assign since_done = now_ms - done_time_q;
	assign since_press = now_ms - press_start_q;
	assign double_min = {2'b00, cfg.refresh_gap_ms} + {1'b0, cfg.debounce_ms, 1'b0};

	always_comb begin
		phase_d = phase_q;
		press_start_d = press_start_q;
		done_time_d = done_time_q;
		hold_pending_d = hold_pending_q;
		kind_d = kind_q;
		res.status = ST_BUSY;
		res.event_fired = KIND_NONE;
		if (since_done < {16'd0, cfg.refresh_gap_ms}) begin
			res.status = ST_REFRESH;
		end else begin
			if (hold_pending_q && since_done > {16'd0, cfg.hold_state_ms}) begin
				hold_pending_d = 1'b0;
				kind_d = KIND_NONE;
			end
			case (phase_q)
				PH_DEBOUNCE: begin
					if (!pressed) begin
						phase_d = PH_IDLE;
						res.status = ST_BOUNCE;
					end else if (since_press >= {16'd0, cfg.debounce_ms}) begin
						phase_d = PH_DETERMINE;
						press_start_d = now_ms;
					end
				end
				PH_DETERMINE: begin
					if (!pressed) begin
						phase_d = PH_SHORT;
					end else if (since_press >= {16'd0, cfg.long_press_ms}) begin
						phase_d = PH_LONG;
					end
				end
				PH_SHORT: begin
					if (cfg.use_double_press) begin
						if (pressed && since_press >= {14'd0, double_min}) begin
							phase_d = PH_DOUBLE;
						end else if (since_press >= {16'd0, cfg.double_gap_ms}) begin
							kind_d = KIND_SHORT;
							res.event_fired = KIND_SHORT;
							phase_d = PH_END;
						end
					end else begin
						kind_d = KIND_SHORT;
						res.event_fired = KIND_SHORT;
						phase_d = PH_END;
					end
				end
				PH_DOUBLE: begin
					kind_d = KIND_DOUBLE;
					res.event_fired = KIND_DOUBLE;
					if (!pressed) begin
						phase_d = PH_END;
					end
				end
				PH_LONG: begin
					kind_d = KIND_LONG;
					res.event_fired = KIND_LONG;
					if (!pressed || cfg.single_long_event) begin
						phase_d = PH_END;
					end
				end
				PH_END: begin
					if (!cfg.single_long_event || !pressed) begin
						phase_d = PH_IDLE;
						hold_pending_d = 1'b1;
						done_time_d = now_ms;
						res.status = ST_DONE;
					end
				end
				default: begin
					if (pressed) begin
						phase_d = PH_DEBOUNCE;
						press_start_d = now_ms;
					end else begin
						phase_d = PH_IDLE;
						res.status = ST_IDLE;
					end
				end
			endcase
		end
		res.press_kind = kind_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			press_start_q <= '0;
			done_time_q <= '0;
			hold_pending_q <= 1'b0;
			kind_q <= KIND_NONE;
		end else if (step) begin
			phase_q <= phase_d;
			press_start_q <= press_start_d;
			done_time_q <= done_time_d;
			hold_pending_q <= hold_pending_d;
			kind_q <= kind_d;
		end
	end

endmodule

// ===== bench/tb_button_press_classifier.sv =====
// Testbench for button_press_classifier: polls from a directed table, then random gestures.
// Each beat is checked against its typed table row or an in-bench classifier of the phases.
// Depends on bpc_pkg and button_press_classifier from the rtl folder.
module tb_button_press_classifier;
	timeunit 1ns;
	timeprecision 1ps;
	import bpc_pkg::*;

	localparam int unsigned POLL_TARGET = 1550;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned PHASE_POLLS = 190;
	localparam int unsigned BACKLOG_CYCLES = 300;
	localparam result_t ANY = '0;

	typedef struct packed {
		logic             level;
		logic [TimeW-1:0] stamp;
		logic             typed;
		result_t          want;
	} script_row_t;

	localparam script_row_t DIRECTED_POLLS [24] = '{
		'{1'b0, 32'd0, 1'b1, '{ST_REFRESH, KIND_NONE, KIND_NONE}},
		'{1'b1, 32'd9, 1'b1, '{ST_REFRESH, KIND_NONE, KIND_NONE}},
		'{1'b0, 32'd10, 1'b1, '{ST_IDLE, KIND_NONE, KIND_NONE}},
		'{1'b1, 32'd100, 1'b0, ANY},
		'{1'b0, 32'd105, 1'b1, '{ST_BOUNCE, KIND_NONE, KIND_NONE}},
		'{1'b1, 32'd200, 1'b0, ANY},
		'{1'b1, 32'd220, 1'b0, ANY},
		'{1'b0, 32'd300, 1'b0, ANY},
		'{1'b0, 32'd301, 1'b0, ANY},
		'{1'b0, 32'd302, 1'b0, ANY},
		'{1'b1, 32'd305, 1'b1, '{ST_REFRESH, KIND_SHORT, KIND_NONE}},
		'{1'b1, 32'd400, 1'b0, ANY},
		'{1'b1, 32'd420, 1'b0, ANY},
		'{1'b1, 32'd1420, 1'b0, ANY},
		'{1'b1, 32'd1421, 1'b0, ANY},
		'{1'b1, 32'd1422, 1'b0, ANY},
		'{1'b0, 32'd1423, 1'b0, ANY},
		'{1'b0, 32'd1424, 1'b0, ANY},
		'{1'b0, 32'd2425, 1'b1, '{ST_IDLE, KIND_NONE, KIND_NONE}},
		'{1'b1, 32'hFFFF_FFF0, 1'b0, ANY},
		'{1'b1, 32'd4, 1'b0, ANY},
		'{1'b0, 32'd5, 1'b0, ANY},
		'{1'b0, 32'd6, 1'b0, ANY},
		'{1'b0, 32'd7, 1'b0, ANY}
	};

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             wr_en = 1'b0;
	logic [IdxW-1:0]  wr_index = '0;
	logic [RegW-1:0]  wr_data = '0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic             raw_level = 1'b0;
	logic [TimeW-1:0] now_ms = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [2:0]       status;
	logic [1:0]       press_kind;
	logic [1:0]       event_fired;

	cfg_t             setting = '{1'b0, 1'b0, 1'b1, 16'd1000, 16'd10, 16'd1000, 16'd300, 16'd20};
	logic [2:0]       gesture_phase = PH_IDLE;
	logic [TimeW-1:0] press_t0 = '0;
	logic [TimeW-1:0] done_at = '0;
	logic             hold_armed = 1'b0;
	logic [1:0]       kind_held = KIND_NONE;

	result_t          classified_polls [$];
	logic [TimeW-1:0] clock_ms = '0;
	int unsigned      polls_sent = 0;
	int unsigned      faults = 0;
	bit               calm = 1'b0;
	bit               backlog_req = 1'b0;
	logic             backlog_hold = 1'b0;

	button_press_classifier DUT (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.raw_level(raw_level),
		.now_ms(now_ms),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.press_kind(press_kind),
		.event_fired(event_fired)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic result_t classify_poll(input logic level, input logic [TimeW-1:0] stamp);
		result_t          r;
		logic             pressed;
		logic [TimeW-1:0] since_done;
		logic [TimeW-1:0] held;
		pressed = (level == setting.active_high);
		since_done = stamp - done_at;
		r.status = ST_BUSY;
		r.event_fired = KIND_NONE;
		if (since_done < TimeW'(setting.refresh_gap_ms)) begin
			r.status = ST_REFRESH;
			r.press_kind = kind_held;
			return r;
		end
		if (hold_armed && since_done > TimeW'(setting.hold_state_ms)) begin
			hold_armed = 1'b0;
			kind_held = KIND_NONE;
		end
		held = stamp - press_t0;
		case (gesture_phase)
			PH_DEBOUNCE: begin
				if (!pressed) begin
					gesture_phase = PH_IDLE;
					r.status = ST_BOUNCE;
				end else if (held >= TimeW'(setting.debounce_ms)) begin
					gesture_phase = PH_DETERMINE;
					press_t0 = stamp;
				end
			end
			PH_DETERMINE: begin
				if (!pressed)
					gesture_phase = PH_SHORT;
				else if (held >= TimeW'(setting.long_press_ms))
					gesture_phase = PH_LONG;
			end
			PH_SHORT: begin
				if (setting.use_double_press && pressed && held >=
						TimeW'(setting.refresh_gap_ms) + (TimeW'(setting.debounce_ms) << 1)) begin
					gesture_phase = PH_DOUBLE;
				end else if (!setting.use_double_press ||
						held >= TimeW'(setting.double_gap_ms)) begin
					kind_held = KIND_SHORT;
					r.event_fired = KIND_SHORT;
					gesture_phase = PH_END;
				end
			end
			PH_DOUBLE: begin
				kind_held = KIND_DOUBLE;
				r.event_fired = KIND_DOUBLE;
				if (!pressed)
					gesture_phase = PH_END;
			end
			PH_LONG: begin
				kind_held = KIND_LONG;
				r.event_fired = KIND_LONG;
				if (!pressed || setting.single_long_event)
					gesture_phase = PH_END;
			end
			PH_END: begin
				if (!setting.single_long_event || !pressed) begin
					gesture_phase = PH_IDLE;
					hold_armed = 1'b1;
					done_at = stamp;
					r.status = ST_DONE;
				end
			end
			default: begin
				if (pressed) begin
					gesture_phase = PH_DEBOUNCE;
					press_t0 = stamp;
				end else begin
					gesture_phase = PH_IDLE;
					r.status = ST_IDLE;
				end
			end
		endcase
		r.press_kind = kind_held;
		return r;
	endfunction

	task automatic offer_poll(input logic level, input logic [TimeW-1:0] stamp, input logic typed,
			input result_t want);
		int unsigned gap;
		result_t     predicted;
		gap = calm ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		raw_level <= level;
		now_ms <= stamp;
		do @(posedge clk); while (in_stall);
		predicted = classify_poll(level, stamp);
		classified_polls.push_back(typed ? want : predicted);
		polls_sent++;
	endtask

	task automatic keep_level(input logic pressed, input int unsigned span);
		int unsigned elapsed;
		int unsigned stride;
		elapsed = 0;
		do begin
			stride = $urandom_range(1, span / 3 + 1);
			clock_ms += stride;
			offer_poll(pressed ? setting.active_high : !setting.active_high, clock_ms, 1'b0, ANY);
			elapsed += stride;
		end while (elapsed < span);
	endtask

	task automatic gesture();
		int unsigned deb;
		int unsigned lng;
		int unsigned gap2;
		int unsigned rfr;
		int unsigned hld;
		int unsigned pick;
		int unsigned n;
		deb = setting.debounce_ms;
		lng = setting.long_press_ms;
		gap2 = setting.double_gap_ms;
		rfr = setting.refresh_gap_ms;
		hld = setting.hold_state_ms;
		pick = $urandom_range(0, 19);
		if (pick < 3) begin
			n = $urandom_range(1, 6);
			repeat (n) begin
				clock_ms += (pick == 0) ? $urandom() : $urandom_range(0, 64);
				offer_poll(1'($urandom_range(0, 1)), clock_ms, 1'b0, ANY);
			end
		end else if (pick < 5) begin
			keep_level(1'b1, deb / 2);
			keep_level(1'b0, rfr);
		end else if (pick < 10) begin
			keep_level(1'b1, deb + $urandom_range(0, lng));
			keep_level(1'b0, $urandom_range(0, gap2 + 8));
		end else if (pick < 13) begin
			keep_level(1'b1, deb + lng + $urandom_range(0, 64));
			keep_level(1'b0, $urandom_range(0, 16));
		end else begin
			keep_level(1'b1, deb + $urandom_range(0, lng / 2));
			keep_level(1'b0, $urandom_range(0, gap2));
			keep_level(1'b1, rfr + 2 * deb + $urandom_range(0, 64));
			keep_level(1'b0, $urandom_range(0, 16));
		end
		keep_level(1'b0, $urandom_range(0, rfr + gap2 + hld + 64));
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (classified_polls.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IdxW-1:0] idx, input logic [RegW-1:0] value);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(posedge clk);
		case (idx)
			REG_USE_DOUBLE:  setting.use_double_press = value[0];
			REG_SINGLE_LONG: setting.single_long_event = value[0];
			REG_ACTIVE_HIGH: setting.active_high = value[0];
			REG_HOLD_STATE:  setting.hold_state_ms = value;
			REG_REFRESH_GAP: setting.refresh_gap_ms = value;
			REG_LONG_PRESS:  setting.long_press_ms = value;
			REG_DOUBLE_GAP:  setting.double_gap_ms = value;
			default:         setting.debounce_ms = value;
		endcase
	endtask

	function automatic logic [RegW-1:0] pick_ms(input int unsigned top);
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return RegW'($urandom_range(1, top));
		endcase
	endfunction

	task automatic load_setting(input int unsigned ph);
		cfg_t s;
		if (ph == 0) begin
			s = '0;
		end else if (ph == 1) begin
			s = '1;
		end else begin
			s.use_double_press = 1'($urandom_range(0, 1));
			s.single_long_event = 1'($urandom_range(0, 1));
			s.active_high = 1'($urandom_range(0, 1));
			s.hold_state_ms = pick_ms(2000);
			s.refresh_gap_ms = pick_ms(40);
			s.long_press_ms = pick_ms(1500);
			s.double_gap_ms = pick_ms(500);
			s.debounce_ms = pick_ms(60);
		end
		write_reg(REG_USE_DOUBLE, RegW'(s.use_double_press));
		write_reg(REG_SINGLE_LONG, RegW'(s.single_long_event));
		write_reg(REG_ACTIVE_HIGH, RegW'(s.active_high));
		write_reg(REG_HOLD_STATE, s.hold_state_ms);
		write_reg(REG_REFRESH_GAP, s.refresh_gap_ms);
		write_reg(REG_LONG_PRESS, s.long_press_ms);
		write_reg(REG_DOUBLE_GAP, s.double_gap_ms);
		write_reg(REG_DEBOUNCE, s.debounce_ms);
		wr_en <= 1'b0;
	endtask

	initial begin : result_drain
		int unsigned pause;
		result_t     want;
		pause = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (classified_polls.size() == 0) begin
					$error("result beat arrived with no poll outstanding");
					faults++;
				end else begin
					want = classified_polls.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						faults++;
					end
					if (press_kind !== want.press_kind) begin
						$error("press_kind: expected %0d, got %0d", want.press_kind, press_kind);
						faults++;
					end
					if (event_fired !== want.event_fired) begin
						$error("event_fired: expected %0d, got %0d", want.event_fired, event_fired);
						faults++;
					end
				end
				pause = calm ? 0 : $urandom_range(0, 16);
			end else if (pause != 0) begin
				pause--;
			end
			out_stall <= (pause != 0) || backlog_hold;
		end
	end

	// The receiver holds off for a long stretch while polls keep coming, so the input backs up.
	initial begin : backlog
		wait (backlog_req);
		@(posedge clk);
		backlog_hold <= 1'b1;
		repeat (BACKLOG_CYCLES) @(posedge clk);
		backlog_hold <= 1'b0;
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles <= CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stimulus
		int unsigned ph;
		int unsigned phase_end;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (DIRECTED_POLLS[i])
			offer_poll(DIRECTED_POLLS[i].level, DIRECTED_POLLS[i].stamp, DIRECTED_POLLS[i].typed,
				DIRECTED_POLLS[i].want);
		ph = 0;
		while (polls_sent < POLL_TARGET) begin
			settle();
			load_setting(ph);
			clock_ms = $urandom();
			calm = (ph % 3 == 2);
			if (ph == 2)
				backlog_req = 1'b1;
			phase_end = polls_sent + PHASE_POLLS;
			if (phase_end > POLL_TARGET)
				phase_end = POLL_TARGET;
			while (polls_sent < phase_end)
				gesture();
			ph++;
		end
		settle();
		if (faults == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
